### rtl/mvd_pkg.sv
// Shared types, constants and helper functions of the MIDI voice dispatcher.
`default_nettype none

package mvd_pkg;

   // Voice count default and the widths that follow from the fixed fields.
   localparam int VOICES_DEFAULT = 16;
   localparam int MAX_RESULTS    = 16;
   localparam int CNT_W          = $clog2(MAX_RESULTS + 1);
   localparam int POS_W          = 13;

   // Status nibbles and the sysex start byte.
   localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
   localparam logic [3:0] TYPE_NOTE_ON  = 4'h9;
   localparam logic [3:0] TYPE_PROGRAM  = 4'hC;
   localparam logic [7:0] SYSEX_START   = 8'hF0;

   // Sysex message layout, counted in received bytes.
   localparam logic [POS_W-1:0] HEADER_LEN  = 13'd6;
   localparam logic [POS_W-1:0] PATCH_END   = 13'd4102;
   localparam logic [POS_W-1:0] SYSEX_TOTAL = 13'd4104;

   localparam logic [4:0] TOP_PATCH = 5'd31;

   // Event kinds on the result channel.
   localparam logic [2:0] KIND_START   = 3'd0;
   localparam logic [2:0] KIND_RELEASE = 3'd1;
   localparam logic [2:0] KIND_PATCH   = 3'd2;
   localparam logic [2:0] KIND_WRITE   = 3'd3;
   localparam logic [2:0] KIND_DROP    = 3'd4;

   typedef struct packed {
      logic [2:0]  event_kind;
      logic [3:0]  voice_slot;
      logic [7:0]  note_number;
      logic [7:0]  note_velocity;
      logic [4:0]  patch_number;
      logic [11:0] patch_address;
      logic [7:0]  patch_byte;
      logic        last;
   } rsp_word_type;

   // Expected byte of the patch-dump header at a given position.
   function automatic logic [7:0] header_byte(input logic [2:0] idx);
      logic [7:0] val;
      case (idx)
         3'd0:    val = 8'hF0;
         3'd1:    val = 8'h43;
         3'd2:    val = 8'h00;
         3'd3:    val = 8'h09;
         3'd4:    val = 8'h20;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

### rtl/mvd_if.sv
// Valid/ready channel interfaces for MIDI input words and dispatcher result words.
`default_nettype none

interface mvd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] midi_byte;

   modport source (output valid, output midi_byte, input ready);
   modport sink   (input valid, input midi_byte, output ready);
endinterface

interface mvd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_kind;
   logic [3:0]  voice_slot;
   logic [7:0]  note_number;
   logic [7:0]  note_velocity;
   logic [4:0]  patch_number;
   logic [11:0] patch_address;
   logic [7:0]  patch_byte;
   logic        last;

   modport source (output valid, output event_kind, output voice_slot, output note_number,
                   output note_velocity, output patch_number, output patch_address,
                   output patch_byte, output last, input ready);
   modport sink   (input valid, input event_kind, input voice_slot, input note_number,
                   input note_velocity, input patch_number, input patch_address,
                   input patch_byte, input last, output ready);
endinterface

`default_nettype wire

### rtl/mvd_voice_table.sv
// Voice slot table: note memory plus active flags, one write and one registered read.
`default_nettype none

module mvd_voice_table #(
   parameter int VOICES = mvd_pkg::VOICES_DEFAULT,
   parameter int SLOT_W = (VOICES > 1) ? $clog2(VOICES) : 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire logic [SLOT_W-1:0] wr_addr,
   input  wire logic [7:0]        wr_note,
   input  wire logic [SLOT_W-1:0] rd_addr,
   output logic [7:0]             rd_note,
   output logic                   rd_active
);

   logic [7:0]        note_mem [VOICES];
   logic [VOICES-1:0] active_ff;
   logic [7:0]        rd_note_ff;
   logic              rd_active_ff;

   // Note entries need no reset: an entry is only trusted when its active flag is set.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         note_mem[wr_addr] <= wr_note;
      end
      rd_note_ff <= note_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= '0;
         rd_active_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            active_ff[wr_addr] <= 1'b1;
         end
         rd_active_ff <= active_ff[rd_addr];
      end
   end

   assign rd_note   = rd_note_ff;
   assign rd_active = rd_active_ff;

endmodule

`default_nettype wire

### rtl/midi_voice_dispatcher.sv
// Top level of the MIDI voice dispatcher: byte parser, voice allocator and release scanner.
`default_nettype none

// The dispatcher takes one MIDI byte per word on req_chan and reports what that byte causes
// as result words on rsp_chan, with last set on the final word of each byte. Most bytes are
// handled in the cycle they are accepted: a status byte, a first data byte or a sysex tail
// byte gives no word, while a note-on, a program change, a patch-dump byte or a dropped byte
// gives one word that sits in the output register until it is taken. The input is ready in
// the idle state whenever the output register is empty or being emptied in the same cycle,
// so a stream of single-word bytes runs at one byte per cycle under a free output. A note-off
// (or a note-on with velocity zero) starts a release scan that visits the voice slots in turn,
// each in a read state and then a compare state, since the note table has one registered read
// port and a single comparator checks each slot; no further byte is taken until the scan is
// back in idle, and the scan reports at most sixteen releases in ascending slot order. The
// scan keeps one matched slot in hand until the next match or the end of the table so that
// the final word carries last.
// Released voices stay marked active; a slot is reused only when the round-robin pointer reaches it.
// Unknown status bytes and bad patch-dump header bytes are reported as dropped words that
// carry the offending byte. There is no clearing pass: only the active flags are reset.

module midi_voice_dispatcher #(
   parameter int VOICES = mvd_pkg::VOICES_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   mvd_req_if.sink    req_chan,
   mvd_rsp_if.source  rsp_chan
);

   localparam int SLOT_W = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(VOICES - 1);

   // Sequencer states.
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_READ   = 2'd1;
   localparam logic [1:0] ST_CMP    = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]              state_ff, state_in;
   logic [3:0]              status_hi_ff, status_hi_in;
   logic [7:0]              first_data_ff, first_data_in;
   logic [mvd_pkg::POS_W-1:0] bytes_ff, bytes_in;
   logic                    in_sysex_ff, in_sysex_in;
   logic [SLOT_W-1:0]       next_voice_ff, next_voice_in;
   logic [4:0]              patch_ff, patch_in;

   // Release scan bookkeeping.
   logic [SLOT_W-1:0]         scan_idx_ff, scan_idx_in;
   logic [mvd_pkg::CNT_W-1:0] count_ff, count_in;
   logic [SLOT_W-1:0]         pend_slot_ff, pend_slot_in;
   logic                      pend_valid_ff, pend_valid_in;

   // Output register.
   logic                  out_valid_ff, out_valid_in;
   mvd_pkg::rsp_word_type out_word_ff, out_word_in;
   logic                  out_load;
   logic                  out_free;

   // Voice table ports.
   logic              tbl_we;
   logic [7:0]        tbl_rd_note;
   logic              tbl_rd_active;

   logic              req_accept;
   logic [7:0]        b;
   logic              status_ok;
   logic              hit;
   logic [mvd_pkg::POS_W-1:0] pos_next;

   mvd_voice_table #(
      .VOICES (VOICES),
      .SLOT_W (SLOT_W)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (tbl_we),
      .wr_addr   (next_voice_ff),
      .wr_note   (first_data_ff),
      .rd_addr   (scan_idx_ff),
      .rd_note   (tbl_rd_note),
      .rd_active (tbl_rd_active)
   );

   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && out_free;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign b              = req_chan.midi_byte;
   assign pos_next       = bytes_ff + 13'd1;
   assign status_ok      = (b[7:4] == mvd_pkg::TYPE_NOTE_OFF) || (b[7:4] == mvd_pkg::TYPE_NOTE_ON)
                        || (b[7:4] == mvd_pkg::TYPE_PROGRAM) || (b == mvd_pkg::SYSEX_START);
   // The single slot comparator used by the release scan.
   assign hit            = tbl_rd_active && (tbl_rd_note == first_data_ff);

   always_comb begin
      state_in      = state_ff;
      status_hi_in  = status_hi_ff;
      first_data_in = first_data_ff;
      bytes_in      = bytes_ff;
      in_sysex_in   = in_sysex_ff;
      next_voice_in = next_voice_ff;
      patch_in      = patch_ff;
      scan_idx_in   = scan_idx_ff;
      count_in      = count_ff;
      pend_slot_in  = pend_slot_ff;
      pend_valid_in = pend_valid_ff;
      out_load      = 1'b0;
      out_word_in   = '0;
      tbl_we        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (bytes_ff == '0) begin
                  // Message start: only a known status byte opens a message.
                  if (status_ok) begin
                     status_hi_in = b[7:4];
                     bytes_in     = 13'd1;
                     in_sysex_in  = (b == mvd_pkg::SYSEX_START);
                  end else begin
                     out_load               = 1'b1;
                     out_word_in.event_kind = mvd_pkg::KIND_DROP;
                     out_word_in.patch_byte = b;
                     out_word_in.last       = 1'b1;
                  end
               end else if (in_sysex_ff) begin
                  if (bytes_ff < mvd_pkg::HEADER_LEN) begin
                     if (b != mvd_pkg::header_byte(bytes_ff[2:0])) begin
                        out_load               = 1'b1;
                        out_word_in.event_kind = mvd_pkg::KIND_DROP;
                        out_word_in.patch_byte = b;
                        out_word_in.last       = 1'b1;
                        bytes_in               = '0;
                        in_sysex_in            = 1'b0;
                     end else begin
                        bytes_in = pos_next;
                     end
                  end else if (bytes_ff < mvd_pkg::PATCH_END) begin
                     out_load                  = 1'b1;
                     out_word_in.event_kind    = mvd_pkg::KIND_WRITE;
                     out_word_in.patch_address = 12'(bytes_ff - mvd_pkg::HEADER_LEN);
                     out_word_in.patch_byte    = b;
                     out_word_in.last          = 1'b1;
                     bytes_in                  = pos_next;
                  end else if (pos_next >= mvd_pkg::SYSEX_TOTAL) begin
                     bytes_in    = '0;
                     in_sysex_in = 1'b0;
                  end else begin
                     bytes_in = pos_next;
                  end
               end else if (status_hi_ff == mvd_pkg::TYPE_PROGRAM) begin
                  patch_in                 = (b > {3'b000, mvd_pkg::TOP_PATCH})
                                           ? mvd_pkg::TOP_PATCH : b[4:0];
                  out_load                 = 1'b1;
                  out_word_in.event_kind   = mvd_pkg::KIND_PATCH;
                  out_word_in.patch_number = patch_in;
                  out_word_in.last         = 1'b1;
                  bytes_in                 = '0;
               end else if (bytes_ff == 13'd1) begin
                  first_data_in = b;
                  bytes_in      = 13'd2;
               end else begin
                  bytes_in = '0;
                  if ((status_hi_ff == mvd_pkg::TYPE_NOTE_OFF) || (b == 8'd0)) begin
                     // Release: walk the voice table from slot zero.
                     state_in      = ST_READ;
                     scan_idx_in   = '0;
                     count_in      = '0;
                     pend_valid_in = 1'b0;
                  end else begin
                     tbl_we                    = 1'b1;
                     out_load                  = 1'b1;
                     out_word_in.event_kind    = mvd_pkg::KIND_START;
                     out_word_in.voice_slot    = 4'(next_voice_ff);
                     out_word_in.note_number   = first_data_ff;
                     out_word_in.note_velocity = b;
                     out_word_in.patch_number  = patch_ff;
                     out_word_in.last          = 1'b1;
                     next_voice_in = (next_voice_ff == LAST_SLOT) ? '0 : next_voice_ff + 1'b1;
                  end
               end
            end
         end

         ST_READ: begin
            // The table registers the entry at scan_idx_ff during this cycle.
            state_in = ST_CMP;
         end

         ST_CMP: begin
            if (hit) begin
               if (!pend_valid_ff || out_free) begin
                  if (pend_valid_ff) begin
                     out_load                = 1'b1;
                     out_word_in.event_kind  = mvd_pkg::KIND_RELEASE;
                     out_word_in.voice_slot  = 4'(pend_slot_ff);
                     out_word_in.note_number = first_data_ff;
                  end
                  pend_slot_in  = scan_idx_ff;
                  pend_valid_in = 1'b1;
                  count_in      = count_ff + 1'b1;
                  if ((count_ff == mvd_pkg::CNT_W'(mvd_pkg::MAX_RESULTS - 1))
                      || (scan_idx_ff == LAST_SLOT)) begin
                     state_in = ST_FINISH;
                  end else begin
                     scan_idx_in = scan_idx_ff + 1'b1;
                     state_in    = ST_READ;
                  end
               end
            end else if (scan_idx_ff == LAST_SLOT) begin
               state_in = ST_FINISH;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
               state_in    = ST_READ;
            end
         end

         ST_FINISH: begin
            // The slot held in hand is the final release and carries last.
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_load                = 1'b1;
               out_word_in.event_kind  = mvd_pkg::KIND_RELEASE;
               out_word_in.voice_slot  = 4'(pend_slot_ff);
               out_word_in.note_number = first_data_ff;
               out_word_in.last        = 1'b1;
               pend_valid_in           = 1'b0;
               state_in                = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         status_hi_ff  <= '0;
         first_data_ff <= '0;
         bytes_ff      <= '0;
         in_sysex_ff   <= 1'b0;
         next_voice_ff <= '0;
         patch_ff      <= '0;
         scan_idx_ff   <= '0;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         status_hi_ff  <= status_hi_in;
         first_data_ff <= first_data_in;
         bytes_ff      <= bytes_in;
         in_sysex_ff   <= in_sysex_in;
         next_voice_ff <= next_voice_in;
         patch_ff      <= patch_in;
         scan_idx_ff   <= scan_idx_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_slot_ff <= pend_slot_in;
      if (out_load) begin
         out_word_ff <= out_word_in;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.event_kind    = out_word_ff.event_kind;
   assign rsp_chan.voice_slot    = out_word_ff.voice_slot;
   assign rsp_chan.note_number   = out_word_ff.note_number;
   assign rsp_chan.note_velocity = out_word_ff.note_velocity;
   assign rsp_chan.patch_number  = out_word_ff.patch_number;
   assign rsp_chan.patch_address = out_word_ff.patch_address;
   assign rsp_chan.patch_byte    = out_word_ff.patch_byte;
   assign rsp_chan.last          = out_word_ff.last;

   // A byte that opens no message must come straight back as a dropped word with last set.
   a_drop_reported: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (bytes_ff == '0) && !status_ok)
      |=> (rsp_chan.valid && (rsp_chan.event_kind == mvd_pkg::KIND_DROP) && rsp_chan.last))
      else $error("dropped status byte was not reported");

   // The release scan never counts more matches than one byte may report.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= mvd_pkg::CNT_W'(mvd_pkg::MAX_RESULTS))
      else $error("release count exceeded its bound");

   // A sysex flag without an open message would misroute the next byte.
   a_sysex_open: assert property (@(posedge clock) disable iff (reset)
      in_sysex_ff |-> (bytes_ff != '0))
      else $error("sysex flag set while no message is open");

   // No release may be held in hand once the scan has returned to idle.
   a_pending_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("pending release left over after scan");

endmodule

`default_nettype wire
